>>> design/ppc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants of the positional PID controller.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int MidDepth = 4;
  localparam int OutDepth = 4;

  localparam logic [1:0] MODE_P   = 2'd0;
  localparam logic [1:0] MODE_PI  = 2'd1;
  localparam logic [1:0] MODE_PID = 2'd2;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_TARGET = 3'd1;
  localparam logic [2:0] REG_GAIN_P = 3'd2;
  localparam logic [2:0] REG_GAIN_I = 3'd3;
  localparam logic [2:0] REG_GAIN_D = 3'd4;

  // word passed from the front to the back
  typedef struct packed {
    logic signed [16:0] error;
    logic signed [31:0] sum;
    logic signed [17:0] diff;
    logic               use_i;
    logic               use_d;
    logic               sum_hit;
  } ppc_item_t;

endpackage
`default_nettype wire

>>> design/ppc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_fifo
// Small register queue with push/full and pop/empty and a fill count.
// ----------------------------------------------------------------------------
module ppc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire logic [WIDTH-1:0]               din,
  output logic                                full,
  input  wire logic                           pop,
  output logic [WIDTH-1:0]                    dout,
  output logic                                empty,
  output logic [$clog2(DEPTH+1)-1:0]          count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule
`default_nettype wire

>>> design/ppc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_front
// Forms the error, updates error sum (PI/PID), last error (PID), emits words.
// ----------------------------------------------------------------------------
module ppc_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire logic signed [15:0]  measured_value,
  input  wire logic [1:0]          mode,
  input  wire logic signed [15:0]  target,
  output ppc_pkg::ppc_item_t       item
);
  import ppc_pkg::*;

  logic signed [31:0] error_sum;
  logic signed [31:0] error_sum_next;
  logic signed [16:0] last_error;
  logic signed [16:0] err;
  logic signed [32:0] sum_wide;
  logic               sum_sat;

  assign err      = $signed({target[15], target}) -
                    $signed({measured_value[15], measured_value});
  assign sum_wide = $signed({error_sum[31], error_sum}) +
                    $signed({{16{err[16]}}, err});
  assign sum_sat  = sum_wide[32] != sum_wide[31];

  always_comb begin
    if (sum_sat) begin
      error_sum_next = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      error_sum_next = sum_wide[31:0];
    end
  end

  always_comb begin
    item.error = err;
    item.sum   = error_sum_next;
    item.diff  = $signed({err[16], err}) - $signed({last_error[16], last_error});
    unique case (mode)
      MODE_PI: begin
        item.use_i   = 1'b1;
        item.use_d   = 1'b0;
        item.sum_hit = sum_sat;
      end
      MODE_PID: begin
        item.use_i   = 1'b1;
        item.use_d   = 1'b1;
        item.sum_hit = sum_sat;
      end
      default: begin
        item.use_i   = 1'b0;
        item.use_d   = 1'b0;
        item.sum_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (take) begin
      if (item.use_i) begin
        error_sum <= error_sum_next;
      end
      if (item.use_d) begin
        last_error <= err;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/ppc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_back
// Multiplies by the gains, sums, scales by 1/256 and saturates.
// ----------------------------------------------------------------------------
module ppc_back #(
  parameter int OUT_DEPTH = ppc_pkg::OutDepth
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire ppc_pkg::ppc_item_t              item,
  input  wire logic                            mid_empty,
  output logic                                 mid_pop,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0]  out_count,
  output logic                                 out_push,
  input  wire logic signed [15:0]              gain_p,
  input  wire logic signed [15:0]              gain_i,
  input  wire logic signed [15:0]              gain_d,
  output logic [31:0]                          drive_value,
  output logic                                 clipped
);
  import ppc_pkg::*;

  localparam int CW = $clog2(OUT_DEPTH+1);

  logic               v1;
  logic signed [32:0] prod_p;
  logic signed [47:0] prod_i;
  logic signed [33:0] prod_d;
  logic               hit1;
  logic signed [32:0] mul_p;
  logic signed [47:0] mul_i;
  logic signed [33:0] mul_d;
  logic [CW:0]        used;
  logic signed [49:0] acc;
  logic [41:0]        scaled;
  logic               drive_sat;

  // in-flight word counts against the output queue
  assign used    = {1'b0, out_count} + {{CW{1'b0}}, v1};
  assign mid_pop = !mid_empty && (used < OUT_DEPTH[CW:0]);

  assign mul_p = gain_p * item.error;
  assign mul_i = gain_i * item.sum;
  assign mul_d = gain_d * item.diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= mid_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      prod_p <= mul_p;
      prod_i <= item.use_i ? mul_i : '0;
      prod_d <= item.use_d ? mul_d : '0;
      hit1   <= item.sum_hit;
    end
  end

  assign acc = $signed({{17{prod_p[32]}}, prod_p}) +
               $signed({{2{prod_i[47]}}, prod_i}) +
               $signed({{16{prod_d[33]}}, prod_d});
  assign scaled    = acc[49:8];
  assign drive_sat = !(&scaled[41:31]) && (|scaled[41:31]);

  always_comb begin
    if (drive_sat) begin
      drive_value = scaled[41] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      drive_value = scaled[31:0];
    end
  end

  assign clipped  = hit1 || drive_sat;
  assign out_push = v1;

endmodule
`default_nettype wire

>>> design/positional_pid_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_pid_controller_top
// Positional PID controller with fixed-point Q8.8 gains.
// ----------------------------------------------------------------------------
// Input channel: a measured sample word is taken at a clock edge with push
// high and full low. Output channel: while empty is low the oldest drive
// word and its clipped flag are on the ports; pop high takes it.
// Configuration: cfg_write with cfg_index 0..4 (mode, target, gain_p,
// gain_i, gain_d) writes cfg_data at the edge; other indexes are ignored.
// Throughput: one word per cycle while the receiver keeps popping. The front
// updates the error sum and last error when a word is taken; the back has
// one multiplier stage followed by the add, scale and saturate logic feeding
// the output queue. A word passes through the middle queue, the multiplier
// stage and the output queue before it is visible on the output.
// Reset clears the registers, the error sum, the last error and both
// queues. When the receiver stops popping, the output queue fills, the
// back stops, the middle queue fills and full rises; no word is lost.
// ----------------------------------------------------------------------------
module positional_pid_controller_top #(
  parameter int MID_DEPTH = ppc_pkg::MidDepth,
  parameter int OUT_DEPTH = ppc_pkg::OutDepth
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [15:0] measured_value,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      drive_value,
  output logic                    clipped,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import ppc_pkg::*;

  localparam int ItemW = $bits(ppc_item_t);
  localparam int OutW  = 33;

  logic [1:0]         mode;
  logic signed [15:0] target;
  logic signed [15:0] gain_p;
  logic signed [15:0] gain_i;
  logic signed [15:0] gain_d;

  ppc_item_t          front_item;
  ppc_item_t          mid_item;
  logic [ItemW-1:0]   mid_dout;
  logic               mid_full;
  logic               mid_empty;
  logic               mid_pop;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  logic               take;

  logic               out_push;
  logic               out_full;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
  logic [31:0]        back_drive;
  logic               back_clipped;
  logic [OutW-1:0]    out_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_P;
      target <= '0;
      gain_p <= '0;
      gain_i <= '0;
      gain_d <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:   mode   <= cfg_data[1:0];
        REG_TARGET: target <= cfg_data;
        REG_GAIN_P: gain_p <= cfg_data;
        REG_GAIN_I: gain_i <= cfg_data;
        REG_GAIN_D: gain_d <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full = mid_full;
  assign take = push && !mid_full;

  ppc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .measured_value (measured_value),
    .mode           (mode),
    .target         (target),
    .item           (front_item)
  );

  ppc_fifo #(
    .WIDTH (ItemW),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_item),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty),
    .count (mid_count)
  );

  assign mid_item = ppc_item_t'(mid_dout);

  ppc_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item        (mid_item),
    .mid_empty   (mid_empty),
    .mid_pop     (mid_pop),
    .out_count   (out_count),
    .out_push    (out_push),
    .gain_p      (gain_p),
    .gain_i      (gain_i),
    .gain_d      (gain_d),
    .drive_value (back_drive),
    .clipped     (back_clipped)
  );

  ppc_fifo #(
    .WIDTH (OutW),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   ({back_clipped, back_drive}),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_dout),
    .empty (empty),
    .count (out_count)
  );

  assign drive_value = out_dout[31:0];
  assign clipped     = out_dout[32];

  a_out_room: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("output queue overrun");

  a_mid_pop: assert property (@(posedge clk) disable iff (rst)
    mid_pop |-> !mid_empty)
    else $error("pop from empty middle queue");

  a_mid_count: assert property (@(posedge clk) disable iff (rst)
    (mid_full == (mid_count == MID_DEPTH[$clog2(MID_DEPTH+1)-1:0])))
    else $error("middle queue full flag mismatch");

  a_reset: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");

endmodule
`default_nettype wire
